// ----- rtl/sictrt_pkg.sv -----
// shared types and constants for the signed integer to radix text unit
`default_nettype none

package sictrt_pkg;

   // sizes
   localparam int unsigned NUMBER_BITS  = 32;
   localparam int unsigned MAX_ALPHABET = 128;
   localparam int unsigned ADDR_BITS    = $clog2(MAX_ALPHABET);
   localparam int unsigned DIGIT_BITS   = ADDR_BITS;
   localparam int unsigned LEN_BITS     = $clog2(MAX_ALPHABET + 1);
   localparam int unsigned CNT_BITS     = $clog2(2 * NUMBER_BITS);
   localparam int unsigned SEEN_BITS    = 7;
   localparam int unsigned SEEN_DEPTH   = 1 << SEEN_BITS;

   // request operations
   localparam logic [1:0] OP_CLEAR   = 2'd0;
   localparam logic [1:0] OP_APPEND  = 2'd1;
   localparam logic [1:0] OP_CONVERT = 2'd2;

   // symbol limits
   localparam logic [7:0] SYM_PLUS  = 8'd43;
   localparam logic [7:0] SYM_MINUS = 8'd45;
   localparam logic [7:0] SYM_LOW   = 8'd32;
   localparam logic [7:0] SYM_HIGH  = 8'd126;

   typedef struct packed {
      logic [1:0]                    operation;
      logic [7:0]                    symbol_byte;
      logic signed [NUMBER_BITS-1:0] number;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       alphabet_invalid;
      logic       last;
   } rsp_type;

   // alphabet load command
   typedef struct packed {
      logic       clear;
      logic       append;
      logic [7:0] symbol;
   } alpha_cmd_type;

   // alphabet status
   typedef struct packed {
      logic                bad;
      logic [LEN_BITS-1:0] length;
   } alpha_status_type;

   // control shared by all digit cells
   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctl_type;

   // data handed from one cell to the next
   typedef struct packed {
      logic                  valid;
      logic                  carry;
      logic [DIGIT_BITS-1:0] digit;
   } cell_link_type;

endpackage

`default_nettype wire

// ----- rtl/sictrt_cell.sv -----
// one radix digit cell: doubles its digit plus incoming carry, modulo the radix
`default_nettype none

module sictrt_cell (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire sictrt_pkg::cell_ctl_type          ctl,
   input  wire logic [sictrt_pkg::LEN_BITS-1:0]   radix,
   input  wire sictrt_pkg::cell_link_type         link_in,
   output sictrt_pkg::cell_link_type              link_out
);

   localparam int unsigned SUM_BITS = sictrt_pkg::LEN_BITS + 1;

   logic [sictrt_pkg::DIGIT_BITS-1:0] digit_ff, digit_in;
   logic                              carry_ff, carry_in;
   logic                              valid_ff, valid_in;
   logic [SUM_BITS-1:0]               sum;
   logic [SUM_BITS-1:0]               diff;

   // twice the digit plus the carry from below, then one conditional subtract
   assign sum  = SUM_BITS'({digit_ff, link_in.carry});
   assign diff = sum - SUM_BITS'(radix);

   always_comb begin
      digit_in = digit_ff;
      carry_in = 1'b0;
      valid_in = 1'b0;
      if (ctl.clear) begin
         digit_in = '0;
      end else if (ctl.shift) begin
         digit_in = link_in.digit;
      end else if (link_in.valid) begin
         valid_in = 1'b1;
         if (sum >= SUM_BITS'(radix)) begin
            digit_in = sictrt_pkg::DIGIT_BITS'(diff);
            carry_in = 1'b1;
         end else begin
            digit_in = sictrt_pkg::DIGIT_BITS'(sum);
         end
      end
   end

   // token travels with the carry so each cell sees its bit in the cycle after the cell below
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
      carry_ff <= carry_in;
   end

   assign link_out.valid = valid_ff;
   assign link_out.carry = carry_ff;
   assign link_out.digit = digit_ff;

endmodule

`default_nettype wire

// ----- rtl/sictrt_alpha.sv -----
// alphabet store with length, seen-symbol set and validity tracking
`default_nettype none

module sictrt_alpha (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire sictrt_pkg::alpha_cmd_type          cmd,
   input  wire logic                               rd_en,
   input  wire logic [sictrt_pkg::ADDR_BITS-1:0]   rd_addr,
   output logic [7:0]                              rd_data,
   output sictrt_pkg::alpha_status_type            status
);

   logic [7:0]                        mem [sictrt_pkg::MAX_ALPHABET];
   logic [7:0]                        rd_data_ff;
   logic [sictrt_pkg::LEN_BITS-1:0]   length_ff, length_in;
   logic                              bad_ff, bad_in;
   logic [sictrt_pkg::SEEN_DEPTH-1:0] seen_ff, seen_in;
   logic                              sym_bad;
   logic                              full;
   logic [sictrt_pkg::SEEN_BITS-1:0]  seen_idx;

   assign sym_bad = (cmd.symbol < sictrt_pkg::SYM_LOW) || (cmd.symbol > sictrt_pkg::SYM_HIGH)
                 || (cmd.symbol == sictrt_pkg::SYM_PLUS)
                 || (cmd.symbol == sictrt_pkg::SYM_MINUS);
   assign full     = (length_ff == sictrt_pkg::LEN_BITS'(sictrt_pkg::MAX_ALPHABET));
   assign seen_idx = cmd.symbol[sictrt_pkg::SEEN_BITS-1:0];

   // clear and append bookkeeping
   always_comb begin
      length_in = length_ff;
      bad_in    = bad_ff;
      seen_in   = seen_ff;
      if (cmd.clear) begin
         length_in = '0;
         bad_in    = 1'b0;
         seen_in   = '0;
      end else if (cmd.append) begin
         if (sym_bad) begin
            bad_in = 1'b1;
         end else begin
            if (seen_ff[seen_idx]) begin
               bad_in = 1'b1;
            end
            seen_in[seen_idx] = 1'b1;
         end
         if (full) begin
            bad_in = 1'b1;
         end else begin
            length_in = length_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         bad_ff    <= 1'b0;
         seen_ff   <= '0;
      end else begin
         length_ff <= length_in;
         bad_ff    <= bad_in;
         seen_ff   <= seen_in;
      end
   end

   // symbol memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.append && !cmd.clear && !full) begin
         mem[length_ff[sictrt_pkg::ADDR_BITS-1:0]] <= cmd.symbol;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data       = rd_data_ff;
   assign status.bad    = bad_ff;
   assign status.length = length_ff;

endmodule

`default_nettype wire

// ----- rtl/signed_integer_to_custom_radix_text_unit.sv -----
// Converts a signed 32-bit number to text in a loadable digit alphabet. Clear and append
// requests load the alphabet and do not hold the unit. A convert request shifts the
// magnitude, most significant bit first, into a row of 32 digit cells, one per radix
// digit; each cell doubles its digit and passes its carry to the next cell in the cycle
// after. The cells then shift out toward the top, skipping leading zero digits; each
// emitted symbol goes through an alphabet read, a result load and a handoff, and a minus
// sign goes out ahead of the digits. A convert on an invalid alphabet returns a single
// result. One request is in work at a time; req_stall is high meanwhile.
`default_nettype none

module signed_integer_to_custom_radix_text_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire sictrt_pkg::req_type  req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output sictrt_pkg::rsp_type       rsp_data
);

   localparam int unsigned N = sictrt_pkg::NUMBER_BITS;
   localparam int unsigned CW = sictrt_pkg::CNT_BITS;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RUN   = 3'd1;
   localparam logic [2:0] ST_SKIP  = 3'd2;
   localparam logic [2:0] ST_FETCH = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]                         state_ff, state_in;
   logic [CW-1:0]                      cnt_ff, cnt_in;
   logic [N-1:0]                       mag_ff, mag_in;
   logic                               neg_ff, neg_in;
   logic                               started_ff, started_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   sictrt_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic                               req_accept;
   logic                               rsp_accept;
   logic                               start;
   logic                               alpha_invalid;
   logic                               rd_en;
   logic [7:0]                         rd_data;
   logic [sictrt_pkg::DIGIT_BITS-1:0]  top_digit;
   sictrt_pkg::alpha_cmd_type          alpha_cmd;
   sictrt_pkg::alpha_status_type       alpha_status;
   sictrt_pkg::cell_ctl_type           cell_ctl;
   sictrt_pkg::cell_link_type          link [N+1];

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign start      = req_accept && (req_data.operation == sictrt_pkg::OP_CONVERT);

   // alphabet store
   assign alpha_cmd.clear  = req_accept && (req_data.operation == sictrt_pkg::OP_CLEAR);
   assign alpha_cmd.append = req_accept && (req_data.operation == sictrt_pkg::OP_APPEND);
   assign alpha_cmd.symbol = req_data.symbol_byte;
   assign alpha_invalid    = alpha_status.bad
                          || (alpha_status.length < sictrt_pkg::LEN_BITS'(2));
   assign top_digit        = link[N].digit;

   sictrt_alpha u_alpha (
      .clock   (clock),
      .reset   (reset),
      .cmd     (alpha_cmd),
      .rd_en   (rd_en),
      .rd_addr (top_digit),
      .rd_data (rd_data),
      .status  (alpha_status)
   );

   // magnitude bits feed the bottom cell
   assign link[0].valid = (state_ff == ST_RUN) && (cnt_ff < CW'(N));
   assign link[0].carry = mag_ff[N-1];
   assign link[0].digit = '0;

   // digit cells, lowest digit first
   for (genvar i = 0; i < N; i++) begin : g_cell
      sictrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl),
         .radix    (alpha_status.length),
         .link_in  (link[i]),
         .link_out (link[i+1])
      );
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_accept;
      rsp_data_in  = rsp_data_ff;
      cell_ctl     = '0;
      rd_en        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (alpha_invalid) begin
                  rsp_valid_in                 = 1'b1;
                  rsp_data_in.out_char         = '0;
                  rsp_data_in.alphabet_invalid = 1'b1;
                  rsp_data_in.last             = 1'b1;
                  state_in                     = ST_OUT;
               end else begin
                  cell_ctl.clear = 1'b1;
                  neg_in         = req_data.number[N-1];
                  mag_in         = req_data.number[N-1] ? N'(~req_data.number + 1'b1)
                                                        : N'(req_data.number);
                  cnt_in         = '0;
                  started_in     = 1'b0;
                  state_in       = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            mag_in = mag_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(2 * N - 2)) begin
               cnt_in = CW'(N);
               if (neg_ff) begin
                  rsp_valid_in                 = 1'b1;
                  rsp_data_in.out_char         = sictrt_pkg::SYM_MINUS;
                  rsp_data_in.alphabet_invalid = 1'b0;
                  rsp_data_in.last             = 1'b0;
                  state_in                     = ST_OUT;
               end else begin
                  state_in = ST_SKIP;
               end
            end
         end
         ST_SKIP: begin
            if (!started_ff && (top_digit == '0) && (cnt_ff > CW'(1))) begin
               cell_ctl.shift = 1'b1;
               cnt_in         = cnt_ff - 1'b1;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            rsp_valid_in                 = 1'b1;
            rsp_data_in.out_char         = rd_data;
            rsp_data_in.alphabet_invalid = 1'b0;
            rsp_data_in.last             = (cnt_ff == CW'(1));
            cell_ctl.shift               = 1'b1;
            cnt_in                       = cnt_ff - 1'b1;
            started_in                   = 1'b1;
            state_in                     = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_accept) begin
               state_in = rsp_data_ff.last ? ST_IDLE : ST_SKIP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/sictrt_checker.sv -----
// port-level checks for the signed integer to radix text unit
`default_nettype none

module sictrt_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire sictrt_pkg::req_type  req_data,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire sictrt_pkg::rsp_type  rsp_data
);

   // an invalid-alphabet result stands alone and carries no symbol
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.alphabet_invalid |-> rsp_data.last && (rsp_data.out_char == 8'd0))
      else $error("invalid-alphabet result not final or carries a symbol");

   // no new request is taken while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result is pending");

   // a convert request occupies the unit on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.operation == sictrt_pkg::OP_CONVERT) |=> req_stall)
      else $error("unit free right after a convert request");

   // alphabet load requests leave the unit free and produce no result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && ((req_data.operation == sictrt_pkg::OP_CLEAR)
         || (req_data.operation == sictrt_pkg::OP_APPEND)) |=> !req_stall && !rsp_valid)
      else $error("alphabet load request held the unit or produced a result");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind signed_integer_to_custom_radix_text_unit sictrt_checker u_sictrt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- test/tb.sv -----
// testbench for the signed integer to radix text unit: directed table, random alphabets
`timescale 1ns / 1ps

module tb;
   import sictrt_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam logic [7:0] NO_CHAR      = 8'h00;
   localparam logic [NUMBER_BITS-1:0] NUM_MIN = {1'b1, {(NUMBER_BITS-1){1'b0}}};
   localparam logic [NUMBER_BITS-1:0] NUM_MAX = {1'b0, {(NUMBER_BITS-1){1'b1}}};
   localparam int RANDOM_ITEMS = 48;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct packed {
      req_type request;
      logic    pinned;
      rsp_type want;
   } dir_row_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // alphabet kept by the predictor
   logic [7:0] alpha_sym [MAX_ALPHABET];
   int         alpha_len = 0;
   bit         alpha_seen [SEEN_DEPTH];
   bit         alpha_bad = 1'b0;

   rsp_type predicted_text [$];
   rsp_type awaited_text [$];
   rsp_type text_want;
   bit      session_used [SEEN_DEPTH];

   int send_idle_pct  = 30;
   int recv_stall_pct = 79;
   int items_sent     = 0;
   int requests_seen  = 0;
   int conversions    = 0;
   int bad_conversions = 0;
   int chars_checked  = 0;
   int error_count    = 0;
   int cycle_count    = 0;

   // directed requests; pinned rows carry their result, the rest go through the predictor
   dir_row_type dir_table [26] = '{
      '{'{OP_CONVERT, 8'h00, 32'h0000_0000}, 1'b1, '{NO_CHAR, 1'b1, 1'b1}},
      '{'{OP_UNUSED,  8'hFF, 32'hFFFF_FFFF}, 1'b0, '0},
      '{'{OP_APPEND,  8'h30, 32'h0000_0000}, 1'b0, '0},
      '{'{OP_CONVERT, 8'h00, 32'h0000_0005}, 1'b1, '{NO_CHAR, 1'b1, 1'b1}},
      '{'{OP_APPEND,  8'h31, 32'h0000_0000}, 1'b0, '0},
      '{'{OP_CONVERT, 8'h00, 32'h0000_0000}, 1'b1, '{8'h30, 1'b0, 1'b1}},
      '{'{OP_CONVERT, 8'h00, NUM_MAX},       1'b0, '0},
      '{'{OP_CONVERT, 8'hFF, NUM_MIN},       1'b0, '0},
      '{'{OP_CONVERT, 8'h00, 32'hFFFF_FFFF}, 1'b0, '0},
      '{'{OP_APPEND,  SYM_PLUS, 32'h0000_0000}, 1'b0, '0},
      '{'{OP_CONVERT, 8'h00, 32'h0000_0001}, 1'b1, '{NO_CHAR, 1'b1, 1'b1}},
      '{'{OP_CLEAR,   8'hFF, 32'hFFFF_FFFF}, 1'b0, '0},
      '{'{OP_APPEND,  8'h00, 32'h0000_0000}, 1'b0, '0},
      '{'{OP_APPEND,  8'h78, 32'h0000_0000}, 1'b0, '0},
      '{'{OP_CONVERT, 8'h00, 32'h0000_0003}, 1'b1, '{NO_CHAR, 1'b1, 1'b1}},
      '{'{OP_CLEAR,   8'h00, 32'h0000_0000}, 1'b0, '0},
      '{'{OP_APPEND,  SYM_LOW, 32'h0000_0000}, 1'b0, '0},
      '{'{OP_APPEND,  SYM_HIGH, 32'h0000_0000}, 1'b0, '0},
      '{'{OP_CONVERT, 8'h00, NUM_MIN},       1'b0, '0},
      '{'{OP_APPEND,  SYM_LOW, 32'h0000_0000}, 1'b0, '0},
      '{'{OP_CONVERT, 8'h00, 32'h0000_0002}, 1'b1, '{NO_CHAR, 1'b1, 1'b1}},
      '{'{OP_CLEAR,   8'h00, 32'h0000_0000}, 1'b0, '0},
      '{'{OP_APPEND,  8'h7F, 32'h0000_0000}, 1'b0, '0},
      '{'{OP_APPEND,  SYM_MINUS, 32'h0000_0000}, 1'b0, '0},
      '{'{OP_CONVERT, 8'h00, 32'h0000_0000}, 1'b1, '{NO_CHAR, 1'b1, 1'b1}},
      '{'{OP_CLEAR,   8'h00, 32'h0000_0000}, 1'b0, '0}
   };

   signed_integer_to_custom_radix_text_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // update the alphabet and work out the text for one request
   function automatic void predict_text(input req_type r);
      logic [NUMBER_BITS-1:0] mag;
      logic [NUMBER_BITS-1:0] radix;
      logic [DIGIT_BITS-1:0]  digits [NUMBER_BITS];
      int nd;
      predicted_text.delete();
      case (r.operation)
         OP_CLEAR: begin
            alpha_len = 0;
            alpha_bad = 1'b0;
            foreach (alpha_seen[i]) alpha_seen[i] = 1'b0;
         end
         OP_APPEND: begin
            if (r.symbol_byte < SYM_LOW || r.symbol_byte > SYM_HIGH ||
                r.symbol_byte == SYM_PLUS || r.symbol_byte == SYM_MINUS) begin
               alpha_bad = 1'b1;
            end else begin
               if (alpha_seen[r.symbol_byte[6:0]]) alpha_bad = 1'b1;
               alpha_seen[r.symbol_byte[6:0]] = 1'b1;
            end
            // a full alphabet drops the byte
            if (alpha_len >= MAX_ALPHABET) begin
               alpha_bad = 1'b1;
            end else begin
               alpha_sym[alpha_len] = r.symbol_byte;
               alpha_len++;
            end
         end
         OP_CONVERT: begin
            conversions++;
            if (alpha_bad || alpha_len < 2) begin
               bad_conversions++;
               predicted_text.push_back(rsp_type'{NO_CHAR, 1'b1, 1'b1});
            end else begin
               // two's complement magnitude, most negative value gives 2^(n-1)
               mag = r.number;
               if (r.number[NUMBER_BITS-1]) mag = ~mag + 1'b1;
               radix = alpha_len;
               nd = 0;
               do begin
                  digits[nd] = DIGIT_BITS'(mag % radix);
                  mag = mag / radix;
                  nd++;
               end while (mag != 0 && nd < NUMBER_BITS);
               if (r.number[NUMBER_BITS-1])
                  predicted_text.push_back(rsp_type'{SYM_MINUS, 1'b0, 1'b0});
               for (int i = nd - 1; i >= 0; i--)
                  predicted_text.push_back(rsp_type'{alpha_sym[digits[i]], 1'b0, i == 0});
            end
         end
         default: ;
      endcase
   endfunction

   // drive one request with random idle ahead of it, then record its expected text
   task automatic send_request(input req_type r, input bit pinned = 1'b0,
                               input rsp_type pinned_rsp = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_seen++;
      if (r.operation != OP_UNUSED) items_sent++;
      predict_text(r);
      if (pinned) begin
         awaited_text.push_back(pinned_rsp);
      end else begin
         foreach (predicted_text[k]) awaited_text.push_back(predicted_text[k]);
      end
   endtask

   // one alphabet load followed by a few conversions
   task automatic run_session();
      logic [7:0] syms [$];
      logic [7:0] s;
      logic [NUMBER_BITS-1:0] num;
      int kind;
      int len;
      int pos;
      int n_conv;
      kind = $urandom_range(99);
      foreach (session_used[i]) session_used[i] = 1'b0;
      if (kind < 80) begin
         len = ($urandom_range(4) == 0) ? $urandom_range(17, 93) : $urandom_range(2, 16);
      end else if (kind < 90) begin
         len = $urandom_range(0, 1);
      end else begin
         len = $urandom_range(1, 8);
      end
      // distinct printable symbols, or raw bytes for noise
      for (int i = 0; i < len; i++) begin
         if (kind >= 90) begin
            s = 8'($urandom());
         end else begin
            do s = 8'($urandom_range(SYM_LOW, SYM_HIGH));
            while (s == SYM_PLUS || s == SYM_MINUS || session_used[s[6:0]]);
            session_used[s[6:0]] = 1'b1;
         end
         syms.push_back(s);
      end
      // spoil one symbol of an otherwise good alphabet
      if (kind >= 65 && kind < 80) begin
         pos = $urandom_range(len - 1);
         case ($urandom_range(5))
            0:       syms[pos] = 8'h00;
            1:       syms[pos] = SYM_PLUS;
            2:       syms[pos] = SYM_MINUS;
            3:       syms[pos] = 8'($urandom_range(0, 31));
            4:       syms[pos] = 8'($urandom_range(127, 255));
            default: syms[pos] = syms[(pos + 1) % len];
         endcase
      end
      if (kind < 95)
         send_request(req_type'{OP_CLEAR, 8'($urandom()), $urandom()});
      foreach (syms[i])
         send_request(req_type'{OP_APPEND, syms[i], $urandom()});
      n_conv = $urandom_range(1, 4);
      for (int i = 0; i < n_conv; i++) begin
         case ($urandom_range(9))
            0:       num = NUM_MIN;
            1:       num = NUM_MAX;
            2:       num = '0;
            3:       num = '1;
            4, 5: begin
               num = $urandom_range(0, 2000);
               if ($urandom_range(1)) num = -num;
            end
            default: num = $urandom();
         endcase
         if ($urandom_range(7) == 0)
            send_request(req_type'{OP_UNUSED, 8'($urandom()), $urandom()});
         send_request(req_type'{OP_CONVERT, 8'($urandom()), num});
      end
   endtask

   // result check against the oldest expectation, then random stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         chars_checked++;
         if (awaited_text.size() == 0) begin
            $error("unexpected result: out_char %0h invalid %0b last %0b",
                   rsp_data.out_char, rsp_data.alphabet_invalid, rsp_data.last);
            error_count++;
         end else begin
            text_want = awaited_text.pop_front();
            if (rsp_data.out_char !== text_want.out_char) begin
               $error("out_char: expected %0h, got %0h", text_want.out_char, rsp_data.out_char);
               error_count++;
            end
            if (rsp_data.alphabet_invalid !== text_want.alphabet_invalid) begin
               $error("alphabet_invalid: expected %0b, got %0b",
                      text_want.alphabet_invalid, rsp_data.alphabet_invalid);
               error_count++;
            end
            if (rsp_data.last !== text_want.last) begin
               $error("last: expected %0b, got %0b", text_want.last, rsp_data.last);
               error_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // run limit
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // stimulus
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i])
         send_request(dir_table[i].request, dir_table[i].pinned, dir_table[i].want);

      // random sessions over three idling phases, at least one session in each
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct  = 79;
            recv_stall_pct = 30;
         end else if (phase == 2) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         do run_session();
         while (items_sent < $size(dir_table) + (phase + 1) * RANDOM_ITEMS / 3);
      end

      // overfill the alphabet past its capacity, then convert
      send_request(req_type'{OP_CLEAR, 8'($urandom()), $urandom()});
      repeat (MAX_ALPHABET + 2)
         send_request(req_type'{OP_APPEND, 8'($urandom()), $urandom()});
      send_request(req_type'{OP_CONVERT, 8'($urandom()), $urandom()});
      req_valid <= 1'b0;

      while (awaited_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests accepted, %0d conversions, %0d of them on an unusable alphabet",
               requests_seen, conversions, bad_conversions);
      $display("%0d result characters checked, %0d mismatches", chars_checked, error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
